@@ rtl/rfp_pkg.sv @@
// types and constants for the radio frame parser with crc-16/kermit check
// no dependencies; imported by rfp_frame and radio_frame_parse_crc_check_unit
package rfp_pkg;

  localparam int unsigned MinFrame = 11;
  localparam int unsigned HdrLen   = 8;
  localparam logic [4:0]  LenMask  = 5'h1F;
  localparam logic [1:0]  VerMask  = 2'h3;
  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [5:0]  CountMax = 6'd63;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StTooShort    = 2'd1,
    StLenMismatch = 2'd2,
    StMsgShort    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } rfp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        crc_ok;
    logic [6:0]  flag_bits;
    logic [1:0]  proto_version;
    logic [4:0]  message_length;
    logic [23:0] dest_address;
    logic [23:0] source_address;
    logic [7:0]  command_id;
    logic [4:0]  payload_length;
    logic [15:0] sequence_res;
  } rfp_out_t;

endpackage

@@ rtl/rfp_frame.sv @@
// per-frame state: byte count, crc-16/kermit over a two-byte delay, header capture
// depends on rfp_pkg; result is combinational from the registered byte and state
module rfp_frame (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  rfp_pkg::rfp_in_t item_i,
  output rfp_pkg::rfp_out_t result_o
);
  import rfp_pkg::*;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [5:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  dly0_q, dly0_d, dly1_q, dly1_d;
  logic [7:0]  ctrl1_q, ctrl1_d, ctrl2_q, ctrl2_d;
  logic [23:0] dest_q, dest_d, src_q, src_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] seq_q, seq_d;

  logic [5:0]  pos;
  logic [4:0]  mlen;
  logic        oneway;
  logic [5:0]  mlen_ext;
  logic [4:0]  need;
  logic [15:0] recv;
  logic [1:0]  status;
  logic        seq_hit;

  always_comb begin
    pos      = count_q;
    crc_d    = (pos >= 6'd2) ? crc_feed(crc_q, dly0_q) : crc_q;
    recv     = {item_i.rx_byte, dly1_q};
    dly0_d   = dly1_q;
    dly1_d   = item_i.rx_byte;

    ctrl1_d  = ctrl1_q;
    ctrl2_d  = ctrl2_q;
    dest_d   = dest_q;
    src_d    = src_q;
    cmd_d    = cmd_q;
    if (pos == 6'd0) begin
      ctrl1_d = item_i.rx_byte;
    end else if (pos == 6'd1) begin
      ctrl2_d = item_i.rx_byte;
    end else if (pos <= 6'd4) begin
      dest_d = {dest_q[15:0], item_i.rx_byte};
    end else if (pos <= 6'd7) begin
      src_d = {src_q[15:0], item_i.rx_byte};
    end else if (pos == 6'd8) begin
      cmd_d = item_i.rx_byte;
    end

    mlen     = ctrl1_d[4:0] & LenMask;
    oneway   = ctrl1_d[5];
    mlen_ext = {1'b0, mlen};
    // sequence number sits just before the six mac bytes and the two crc bytes
    seq_hit  = (pos >= 6'd9) && oneway && (mlen >= 5'(2 * HdrLen)) &&
               ((pos == mlen_ext - 6'd7) || (pos == mlen_ext - 6'd6));
    seq_d    = seq_hit ? {seq_q[7:0], item_i.rx_byte} : seq_q;

    count_d  = (count_q < CountMax) ? count_q + 6'd1 : count_q;

    need     = oneway ? 5'(2 * HdrLen) : 5'(HdrLen);
    if (count_d < 6'(MinFrame)) begin
      status = StTooShort;
    end else if (count_d != mlen_ext + 6'd3) begin
      status = StLenMismatch;
    end else if (mlen < need) begin
      status = StMsgShort;
    end else begin
      status = StOk;
    end

    result_o        = '0;
    result_o.status = status;
    if (status == StOk) begin
      result_o.crc_ok         = (recv == crc_d);
      result_o.flag_bits      = {ctrl1_d[7:5], ctrl2_d[7:4]};
      result_o.proto_version  = ctrl2_d[1:0] & VerMask;
      result_o.message_length = mlen;
      result_o.dest_address   = dest_d;
      result_o.source_address = src_d;
      result_o.command_id     = cmd_d;
      result_o.payload_length = mlen - need;
      result_o.sequence_res   = oneway ? seq_d : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      dly0_q  <= '0;
      dly1_q  <= '0;
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      dest_q  <= '0;
      src_q   <= '0;
      cmd_q   <= '0;
      seq_q   <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // frame closed, start the next one clean
        count_q <= '0;
        crc_q   <= '0;
        dly0_q  <= '0;
        dly1_q  <= '0;
        ctrl1_q <= '0;
        ctrl2_q <= '0;
        dest_q  <= '0;
        src_q   <= '0;
        cmd_q   <= '0;
        seq_q   <= '0;
      end else begin
        count_q <= count_d;
        crc_q   <= crc_d;
        dly0_q  <= dly0_d;
        dly1_q  <= dly1_d;
        ctrl1_q <= ctrl1_d;
        ctrl2_q <= ctrl2_d;
        dest_q  <= dest_d;
        src_q   <= src_d;
        cmd_q   <= cmd_d;
        seq_q   <= seq_d;
      end
    end
  end

endmodule

@@ rtl/radio_frame_parse_crc_check_unit.sv @@
// top level of the radio frame parser: input register, frame logic, result register
// depends on rfp_pkg and rfp_frame
//
//   channel | direction | payload   | handshake
//   --------+-----------+-----------+-------------------------
//   in      | input     | rfp_in_t  | in_valid_i / in_ready_o
//   out     | output    | rfp_out_t | out_valid_o / out_ready_i
//
// one byte per cycle while the input is not stalled; a byte is registered, then processed when the input stage advances
// a result is registered and offered once the input stage holding last_byte advances
// the input stalls only while a last byte waits for a full, stalled result register
// reset clears the frame state and both valid flags
module radio_frame_parse_crc_check_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rfp_pkg::rfp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rfp_pkg::rfp_out_t out_data_o
);
  import rfp_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  rfp_in_t  s1_q;
  logic     out_valid_q, out_valid_d;
  rfp_out_t out_q;
  rfp_out_t result;
  logic     out_free;
  logic     s1_adv;
  logic     in_acc;

  rfp_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_q),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  // bytes without last_byte never need the result register
  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv && s1_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |->
      !out_data_o.crc_ok && (out_data_o.dest_address == '0) &&
      (out_data_o.sequence_res == '0) && (out_data_o.flag_bits == '0))
    else $error("failed frame carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_q.last_byte && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked last byte");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_q.last_byte))
    else $error("result raised without a closing byte");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && !(s1_adv && s1_q.last_byte) |=> $stable(out_q))
    else $error("stalled result overwritten");
`endif

endmodule
